// ----- rtl/core/rbvt_pkg.sv -----
// ----------------------------------------------------------------------------
// rbvt_pkg: shared types and constants of the rigid bone vertex transform
// Bone table entry layout, load request bundle, sine polynomial constants.
// ----------------------------------------------------------------------------
package rbvt_pkg;

  // Default sizes
  localparam int BONE_COUNT_DEF  = 256;
  localparam int COORD_WIDTH_DEF = 32;

  // Field widths of the stream beats
  localparam int IN_DATA_W  = 248;
  localparam int OUT_DATA_W = 96;

  // Angle and fixed-point constants
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [32:0] HALF_Q14     = 33'd8192;
  localparam logic [18:0] ONE_Q16      = 19'd65536;

  // Taylor coefficients of sin(pi/2 * x), unsigned Q30
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598668;
  localparam logic [30:0] K5 = 31'd85569306;
  localparam logic [30:0] K7 = 31'd5026995;
  localparam logic [30:0] K9 = 31'd172272;

  // Bone load sequencer states
  typedef enum logic [2:0] {
    LD_IDLE,
    LD_SETUP,
    LD_MUL,
    LD_ACC,
    LD_WRITE
  } ld_state_t;

  // One bone table entry, index 0..2 is axis x..z
  typedef struct packed {
    logic [2:0][31:0] pivot;
    logic [2:0][31:0] node;
    logic [2:0][17:0] cosv;
    logic [2:0][17:0] sinv;
  } bone_entry_t;

  // Payload of a bone load beat
  typedef struct packed {
    logic [2:0][15:0] angle;
    logic [2:0][31:0] pivot;
    logic [2:0][31:0] node;
  } load_req_t;

endpackage

// ----- rtl/core/rbvt_bone_load.sv -----
// ----------------------------------------------------------------------------
// rbvt_bone_load: bone load sequencer
// Evaluates sine and cosine of the three bone angles with one shared
// multiplier (odd degree-9 polynomial, Horner form) and writes the entry.
// ----------------------------------------------------------------------------
module rbvt_bone_load
  import rbvt_pkg::*;
#(
  parameter int  BONE_COUNT = BONE_COUNT_DEF,
  localparam int IW         = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [IW-1:0]          start_addr,
  input  load_req_t              start_req,
  output logic                   busy,
  output logic                   wr_en,
  output logic [IW-1:0]          wr_addr,
  output bone_entry_t            wr_data
);

  ld_state_t state, state_next;

  logic [2:0]      idx;
  logic [2:0]      step;
  logic [30:0]     x;
  logic [30:0]     x2;
  logic [30:0]     t;
  logic [61:0]     prod;
  load_req_t       req;
  logic [IW-1:0]   addr;
  logic [17:0]     sines [6];

  // current angle: even index sine, odd index cosine
  logic [15:0]     ang_sel;
  logic [14:0]     rr;
  logic [30:0]     opa, opb;
  logic [30:0]     kc;
  logic [32:0]     rnd;
  logic [16:0]     mag;
  logic [17:0]     sv;

  always_comb begin
    ang_sel = req.angle[idx[2:1]] + (idx[0] ? QUARTER_TURN : 16'd0);
    rr = ang_sel[14] ? (15'(QUARTER_TURN) - {1'b0, ang_sel[13:0]})
                     : {1'b0, ang_sel[13:0]};
  end

  // multiplier operands per polynomial step
  always_comb begin
    unique case (step)
      3'd0:    begin opa = x;  opb = x; end
      3'd5:    begin opa = x;  opb = t; end
      default: begin opa = x2; opb = t; end
    endcase
    unique case (step)
      3'd1:    kc = K7;
      3'd2:    kc = K5;
      3'd3:    kc = K3;
      default: kc = K1;
    endcase
  end

  // round Q30 to Q16, clamp to one, apply quadrant sign
  always_comb begin
    rnd = {1'b0, prod[61:30]} + HALF_Q14;
    mag = (rnd[32:14] > ONE_Q16) ? ONE_Q16[16:0] : rnd[30:14];
    sv  = ang_sel[15] ? (18'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    busy  = 1'b1;
    wr_en = 1'b0;
    unique case (state)
      LD_IDLE: begin
        busy = 1'b0;
        if (start) state_next = LD_SETUP;
      end
      LD_SETUP: state_next = LD_MUL;
      LD_MUL:   state_next = LD_ACC;
      LD_ACC: begin
        if (step == 3'd5) state_next = (idx == 3'd5) ? LD_WRITE : LD_SETUP;
        else              state_next = LD_MUL;
      end
      LD_WRITE: begin
        wr_en      = 1'b1;
        state_next = LD_IDLE;
      end
      default: state_next = LD_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      LD_IDLE: begin
        if (start) begin
          req  <= start_req;
          addr <= start_addr;
          idx  <= 3'd0;
        end
      end
      LD_SETUP: begin
        x    <= {rr, 16'd0};
        step <= 3'd0;
      end
      LD_MUL: prod <= 62'(opa) * 62'(opb);
      LD_ACC: begin
        step <= step + 3'd1;
        if (step == 3'd0) begin
          x2 <= prod[60:30];
          t  <= K9;
        end else if (step == 3'd5) begin
          sines[idx] <= sv;
          idx <= idx + 3'd1;
        end else begin
          t <= 31'({1'b0, kc} - prod[61:30]);
        end
      end
      default: ;
    endcase
  end

  // entry assembly
  always_comb begin
    wr_addr       = addr;
    wr_data.pivot = req.pivot;
    wr_data.node  = req.node;
    for (int i = 0; i < 3; i++) begin
      wr_data.sinv[i] = sines[2 * i];
      wr_data.cosv[i] = sines[2 * i + 1];
    end
  end

endmodule

// ----- rtl/core/rigid_bone_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// rigid_bone_vertex_transform: rigid one-bone vertex skinning
// Pivot subtract, Euler x-y-z rotation, node add, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the beat kind (0 vertex, 1 bone load),
//   s_tlast marks the last vertex of a mesh. Output stream m_*: one beat
//   per vertex with the transformed position; m_tlast copies s_tlast.
//   Load beats produce no output.
//   Vertices: one beat per cycle sustained unless m_tready is low or a
//   bone load is busy. m_tvalid rises once the beat, loaded into the first
//   of nine register stages at the accepting edge, has moved through them
//   (table read, pivot subtract, three rotations of a multiply stage and a
//   round stage each, node add into the output reg). Bone load: the angle
//   sine/cosine values come from one shared multiplier; s_tready stays low
//   after a load beat while the entry is computed and written. Loads must
//   precede their vertices. Reset clears the pipeline valid bits and the
//   load sequencer; the bone table holds undefined data until loaded.
//   When m_tready is low the pipeline stages fill up one by one; input
//   stops only once no empty stage is left, and nothing is dropped.
// ----------------------------------------------------------------------------
module rigid_bone_vertex_transform
  import rbvt_pkg::*;
#(
  parameter int BONE_COUNT  = BONE_COUNT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // bone_index[7:0] coord_x[39:8] coord_y[71:40] coord_z[103:72]
  // angle_x[119:104] angle_y[135:120] angle_z[151:136]
  // node_x[183:152] node_y[215:184] node_z[247:216]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x[31:0] out_y[63:32] out_z[95:64]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int IW  = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
  localparam int W   = COORD_WIDTH;
  localparam int DW  = (W >= 33) ? W + 1 : 34;
  localparam int PW  = W + 18;
  localparam int MSW = W + 19;
  localparam int AW  = ((W > 32) ? W : 32) + 1;
  localparam int NS  = 9;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [MSW-1:0] HALF_Q16 = MSW'(32768);

  // saturation helpers
  function automatic logic signed [W-1:0] sat_d(input logic signed [DW-1:0] v);
    logic [DW-W:0] up;
    up = v[DW-1:W-1];
    if (!v[DW-1] && (|up)) return CMAX;
    else if (v[DW-1] && !(&up)) return CMIN;
    else return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_m(input logic signed [MSW-1:0] v);
    logic [MSW-W:0] up;
    up = v[MSW-1:W-1];
    if (!v[MSW-1] && (|up)) return CMAX;
    else if (v[MSW-1] && !(&up)) return CMIN;
    else return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_a(input logic signed [AW-1:0] v);
    logic [AW-W:0] up;
    up = v[AW-1:W-1];
    if (!v[AW-1] && (|up)) return CMAX;
    else if (v[AW-1] && !(&up)) return CMIN;
    else return v[W-1:0];
  endfunction

  function automatic logic [31:0] sat_o(input logic signed [AW-1:0] v);
    logic [AW-32:0] up;
    up = v[AW-1:31];
    if (!v[AW-1] && (|up)) return 32'h7FFF_FFFF;
    else if (v[AW-1] && !(&up)) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  // (a +/- b) / 65536, rounded half up, saturated
  function automatic logic signed [W-1:0] mac_rnd(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b,
                                                  input logic neg);
    logic signed [MSW-1:0] s;
    s = MSW'(a) + (neg ? -MSW'(b) : MSW'(b)) + HALF_Q16;
    return sat_m(s >>> 16);
  endfunction

  function automatic logic [31:0] node_add(input logic signed [W-1:0] p,
                                           input logic [31:0] n);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] u;
    s = AW'(p) + AW'($signed(n));
    u = AW'(sat_a(s));
    return sat_o(u);
  endfunction

  // bone index wraps modulo the table size
  function automatic logic [IW-1:0] wrap_index(input logic [7:0] v);
    logic [20:0] r;
    r = 21'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (21'(BONE_COUNT) << k)) r = r - (21'(BONE_COUNT) << k);
    end
    return r[IW-1:0];
  endfunction

  // input beat decode
  logic [IW-1:0] in_addr;
  load_req_t     in_req;
  logic          ld_busy;
  logic          ld_wr_en;
  logic [IW-1:0] ld_wr_addr;
  bone_entry_t   ld_wr_data;
  logic          acc_load;
  logic          acc_vtx;

  always_comb begin
    in_addr         = wrap_index(s_tdata[7:0]);
    in_req.pivot[0] = s_tdata[39:8];
    in_req.pivot[1] = s_tdata[71:40];
    in_req.pivot[2] = s_tdata[103:72];
    in_req.angle[0] = s_tdata[119:104];
    in_req.angle[1] = s_tdata[135:120];
    in_req.angle[2] = s_tdata[151:136];
    in_req.node[0]  = s_tdata[183:152];
    in_req.node[1]  = s_tdata[215:184];
    in_req.node[2]  = s_tdata[247:216];
  end

  // stage enables: a stage moves when empty or when its successor moves
  logic [NS:1] v;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v[NS] || m_tready;
    for (int k = NS - 1; k >= 1; k--) en[k] = !v[k] || en[k + 1];
  end

  assign s_tready = en[1] && !ld_busy;
  assign acc_load = s_tvalid && s_tready && s_tuser;
  assign acc_vtx  = s_tvalid && s_tready && !s_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= acc_vtx;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k - 1];
      end
    end
  end

  // bone load sequencer
  rbvt_bone_load #(
    .BONE_COUNT (BONE_COUNT)
  ) u_load (
    .clk        (clk),
    .rst        (rst),
    .start      (acc_load),
    .start_addr (in_addr),
    .start_req  (in_req),
    .busy       (ld_busy),
    .wr_en      (ld_wr_en),
    .wr_addr    (ld_wr_addr),
    .wr_data    (ld_wr_data)
  );

  // bone table, registered read into stage 1
  bone_entry_t bone_mem [BONE_COUNT];
  bone_entry_t ent1, ent2, ent3, ent4, ent5, ent6, ent7, ent8;

  always_ff @(posedge clk) begin
    if (ld_wr_en) bone_mem[ld_wr_addr] <= ld_wr_data;
    if (en[1]) ent1 <= bone_mem[in_addr];
  end

  // pipeline payload
  logic [31:0]           cin1 [3];
  logic signed [W-1:0]   x2, y2, z2;
  logic signed [PW-1:0]  prod3 [4];
  logic signed [W-1:0]   x3;
  logic signed [W-1:0]   x4, y4, z4;
  logic signed [PW-1:0]  prod5 [4];
  logic signed [W-1:0]   z5;
  logic signed [W-1:0]   x6, y6, z6;
  logic signed [PW-1:0]  prod7 [4];
  logic signed [W-1:0]   y7;
  logic signed [W-1:0]   x8, y8, z8;
  logic [NS-1:1]         last;

  // stage 1: capture coordinates
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cin1[0] <= s_tdata[39:8];
      cin1[1] <= s_tdata[71:40];
      cin1[2] <= s_tdata[103:72];
      last[1] <= s_tlast;
    end
  end

  // stage 2: subtract pivot
  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2 <= sat_d(DW'($signed(cin1[0])) - DW'($signed(ent1.pivot[0])));
      y2 <= sat_d(DW'($signed(cin1[1])) - DW'($signed(ent1.pivot[1])));
      z2 <= sat_d(DW'($signed(cin1[2])) - DW'($signed(ent1.pivot[2])));
      ent2 <= ent1;
      last[2] <= last[1];
    end
  end

  // stage 3: products for minus x angle, y-z plane
  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod3[0] <= PW'($signed(ent2.cosv[0])) * PW'(z2);
      prod3[1] <= PW'($signed(ent2.sinv[0])) * PW'(y2);
      prod3[2] <= PW'($signed(ent2.sinv[0])) * PW'(z2);
      prod3[3] <= PW'($signed(ent2.cosv[0])) * PW'(y2);
      x3 <= x2;
      ent3 <= ent2;
      last[3] <= last[2];
    end
  end

  // stage 4: round
  always_ff @(posedge clk) begin
    if (en[4]) begin
      z4 <= mac_rnd(prod3[0], prod3[1], 1'b0);
      y4 <= mac_rnd(prod3[3], prod3[2], 1'b1);
      x4 <= x3;
      ent4 <= ent3;
      last[4] <= last[3];
    end
  end

  // stage 5: products for minus y angle, x-y plane
  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod5[0] <= PW'($signed(ent4.cosv[1])) * PW'(y4);
      prod5[1] <= PW'($signed(ent4.sinv[1])) * PW'(x4);
      prod5[2] <= PW'($signed(ent4.cosv[1])) * PW'(x4);
      prod5[3] <= PW'($signed(ent4.sinv[1])) * PW'(y4);
      z5 <= z4;
      ent5 <= ent4;
      last[5] <= last[4];
    end
  end

  // stage 6: round
  always_ff @(posedge clk) begin
    if (en[6]) begin
      y6 <= mac_rnd(prod5[0], prod5[1], 1'b0);
      x6 <= mac_rnd(prod5[2], prod5[3], 1'b1);
      z6 <= z5;
      ent6 <= ent5;
      last[6] <= last[5];
    end
  end

  // stage 7: products for plus z angle, z-x plane
  always_ff @(posedge clk) begin
    if (en[7]) begin
      prod7[0] <= PW'($signed(ent6.cosv[2])) * PW'(x6);
      prod7[1] <= PW'($signed(ent6.sinv[2])) * PW'(z6);
      prod7[2] <= PW'($signed(ent6.sinv[2])) * PW'(x6);
      prod7[3] <= PW'($signed(ent6.cosv[2])) * PW'(z6);
      y7 <= y6;
      ent7 <= ent6;
      last[7] <= last[6];
    end
  end

  // stage 8: round
  always_ff @(posedge clk) begin
    if (en[8]) begin
      x8 <= mac_rnd(prod7[0], prod7[1], 1'b1);
      z8 <= mac_rnd(prod7[2], prod7[3], 1'b0);
      y8 <= y7;
      ent8 <= ent7;
      last[8] <= last[7];
    end
  end

  // stage 9: add node, output register
  always_ff @(posedge clk) begin
    if (en[9]) begin
      m_tdata[31:0]  <= node_add(x8, ent8.node[0]);
      m_tdata[63:32] <= node_add(y8, ent8.node[1]);
      m_tdata[95:64] <= node_add(z8, ent8.node[2]);
      m_tlast        <= last[8];
    end
  end

  assign m_tvalid = v[NS];

endmodule

// ----- rtl/core/rbvt_checker.sv -----
// ----------------------------------------------------------------------------
// rbvt_checker: port-level checks of the rigid bone vertex transform
// Output beat hold rules, reset state and input blocking after a bone load.
// ----------------------------------------------------------------------------
module rbvt_checker
  import rbvt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // a stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a bone load blocks the input while its entry is computed
  a_load_block: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input accepted during bone load");

endmodule

bind rigid_bone_vertex_transform rbvt_checker u_rbvt_checker (.*);
